// ----- design/tpg_pkg.sv -----
package tpg_pkg;

	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int LIMIT_W = 31;
	localparam int MAG_W   = 45;
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ACC_POS,
		ACC_ZERO,
		ACC_NEG
	} acc_sel_t;

	typedef enum logic [1:0] {
		REG_START = 2'd0,
		REG_END   = 2'd1,
		REG_SPEED = 2'd2,
		REG_ACCEL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] start_pos;
		logic signed [WORD_W-1:0] end_pos;
		logic [LIMIT_W-1:0]       speed;
		logic [LIMIT_W-1:0]       accel;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] ramp;
		logic [WORD_W-1:0] dur;
		logic [WORD_W-1:0] peak;
		logic              tri_flag;
		logic              busy;
	} drv_t;

	function automatic logic [WORD_W-1:0] sat_time(input logic [63:0] t);
		return (t[63:WORD_W] != '0) ? '1 : t[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] sat_s32(input logic signed [47:0] v);
		if (v > 48'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -48'sd2147483648)
			return 32'h8000_0000;
		return v[WORD_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] cap_mag(input logic [63:0] m);
		return (m > 64'(MAG_CAP)) ? MAG_CAP : m[MAG_W-1:0];
	endfunction

endpackage

// ----- design/trapezoidal_profile_generator_unit.sv -----
// Channel  Handshake             Payload
// cfg      cfg_we                cfg_index, cfg_data
// in       in_valid / in_stall   sample_time
// out      out_valid / out_stall position_out, velocity_out, accel_out, motion_phase,
//                                total_time, triangular_profile
// Items pass through registered stages; one item can enter in every cycle in which
// in_stall is low. A configuration write starts, in the cycle after it, a shift-add,
// optional square-root and divide run; in_stall is held high from the write to its end.
// Reset is asynchronous and active low and leaves the profile for reset configuration.
// A stall on the output fills the pipeline bubbles first; no item is lost or repeated.
module trapezoidal_profile_generator_unit import tpg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [WORD_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [WORD_W-1:0]        sample_time,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] position_out,
	output logic signed [WORD_W-1:0] velocity_out,
	output logic signed [WORD_W-1:0] accel_out,
	output logic [1:0]               motion_phase,
	output logic [WORD_W-1:0]        total_time,
	output logic                     triangular_profile
);

	cfg_t cfg_q;
	drv_t drv;
	logic cfg_pend_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [31:0] x_s1, dt_s1, x_s2;
	phase_t      ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	acc_sel_t    ac_s1, ac_s2, ac_s3, ac_s4;
	logic [62:0] ax_s2;
	logic [63:0] cv_s2;
	logic [62:0] phi_s3;
	logic [63:0] plo_s3;
	logic [MAG_W-1:0] vm_s3, cr_s3, vm_s4;
	logic [MAG_W:0]   pm_s4;
	logic signed [WORD_W-1:0] pos_s5, vel_s5, acc_s5;

	logic [LIMIT_W-1:0] a_nz;
	logic               up;
	logic [31:0]        t_clamp, t_end;
	phase_t             ph_in;
	acc_sel_t           ac_in;
	logic [31:0]        x_in;
	logic [95:0]        full;
	logic [MAG_W-1:0]   rm;
	logic               add;
	logic signed [47:0] base, pm_sg, pos_sum, vel_sum, a_sg;

	tpg_derive u_derive (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_pend_q),
		.cfg    (cfg_q),
		.drv    (drv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pos <= '0;
			cfg_q.end_pos   <= '0;
			cfg_q.speed     <= LIMIT_W'(1) << FRAC_W;
			cfg_q.accel     <= LIMIT_W'(1) << FRAC_W;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START: cfg_q.start_pos <= cfg_data;
				REG_END:   cfg_q.end_pos   <= cfg_data;
				REG_SPEED: cfg_q.speed     <= cfg_data[LIMIT_W-1:0];
				REG_ACCEL: cfg_q.accel     <= cfg_data[LIMIT_W-1:0];
				default:   cfg_q.accel     <= cfg_q.accel;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_pend_q <= 1'b0;
		else
			cfg_pend_q <= cfg_we;
	end

	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1 || drv.busy || cfg_we || cfg_pend_q;

	always_comb begin
		a_nz    = (cfg_q.accel == '0) ? LIMIT_W'(1) : cfg_q.accel;
		up      = cfg_q.end_pos > cfg_q.start_pos;
		t_clamp = (sample_time > drv.dur) ? drv.dur : sample_time;
		t_end   = (drv.dur > drv.ramp) ? drv.dur - drv.ramp : '0;
		if (t_clamp <= drv.ramp) begin
			ph_in = PH_ACCEL;
			x_in  = t_clamp;
		end else if (t_clamp <= t_end) begin
			ph_in = PH_CRUISE;
			x_in  = drv.ramp;
		end else begin
			ph_in = PH_DECEL;
			x_in  = drv.dur - t_clamp;
		end
		if (t_clamp < drv.ramp)
			ac_in = ACC_POS;
		else if (t_clamp < t_end)
			ac_in = ACC_ZERO;
		else
			ac_in = ACC_NEG;
	end

	always_comb begin
		full  = {1'b0, phi_s3, 32'b0} + {32'b0, plo_s3};
		rm    = cap_mag({1'b0, full[95:33]});
		add   = up ^ (ph_s4 == PH_DECEL);
		base  = (ph_s4 == PH_DECEL) ? 48'(cfg_q.end_pos) : 48'(cfg_q.start_pos);
		pm_sg = $signed({2'b0, pm_s4});
		pos_sum = add ? base + pm_sg : base - pm_sg;
		vel_sum = up ? $signed({3'b0, vm_s4}) : -$signed({3'b0, vm_s4});
		a_sg    = $signed({17'b0, a_nz});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid && !in_stall;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
			if (rdy5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			x_s1  <= x_in;
			dt_s1 <= t_clamp - drv.ramp;
			ph_s1 <= ph_in;
			ac_s1 <= ac_in;
		end
		if (rdy2 && v_s1) begin
			ax_s2 <= 63'(a_nz) * 63'(x_s1);
			cv_s2 <= 64'(drv.peak) * 64'(dt_s1);
			x_s2  <= x_s1;
			ph_s2 <= ph_s1;
			ac_s2 <= ac_s1;
		end
		if (rdy3 && v_s2) begin
			phi_s3 <= 63'(ax_s2[62:32]) * 63'(x_s2);
			plo_s3 <= 64'(ax_s2[31:0]) * 64'(x_s2);
			vm_s3  <= cap_mag({17'b0, ax_s2[62:16]});
			cr_s3  <= cap_mag({16'b0, cv_s2[63:16]});
			ph_s3  <= ph_s2;
			ac_s3  <= ac_s2;
		end
		if (rdy4 && v_s3) begin
			pm_s4 <= {1'b0, rm} + ((ph_s3 == PH_CRUISE) ? {1'b0, cr_s3} : '0);
			vm_s4 <= (ph_s3 == PH_CRUISE) ? {13'b0, drv.peak} : vm_s3;
			ph_s4 <= ph_s3;
			ac_s4 <= ac_s3;
		end
		if (rdy5 && v_s4) begin
			pos_s5 <= sat_s32(pos_sum);
			vel_s5 <= sat_s32(vel_sum);
			ph_s5  <= ph_s4;
			case (ac_s4)
				ACC_POS:  acc_s5 <= sat_s32(up ? a_sg : -a_sg);
				ACC_NEG:  acc_s5 <= sat_s32(up ? -a_sg : a_sg);
				default:  acc_s5 <= '0;
			endcase
		end
	end

	assign out_valid          = v_s5;
	assign position_out       = pos_s5;
	assign velocity_out       = vel_s5;
	assign accel_out          = acc_s5;
	assign motion_phase       = ph_s5;
	assign total_time         = drv.dur;
	assign triangular_profile = drv.tri_flag;

endmodule

// ----- design/tpg_derive.sv -----
module tpg_derive import tpg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cfg_t cfg,
	output drv_t drv
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_DA,
		S_MUL_VV,
		S_SQRT,
		S_DIV_TA,
		S_DIV_VVA,
		S_DIV_CR
	} state_t;

	state_t            state_q;
	logic [63:0]       op_a_q;
	logic [63:0]       op_b_q;
	logic [63:0]       res_q;
	logic [34:0]       rem_q;
	logic [31:0]       root_q;
	logic [LIMIT_W-1:0] dv_q;
	logic [5:0]        cnt_q;
	logic [63:0]       prod_da_q;
	logic [63:0]       prod_vv_q;
	logic [63:0]       ta_q;
	logic [WORD_W-1:0] ramp_q;
	logic [WORD_W-1:0] dur_q;
	logic [WORD_W-1:0] peak_q;
	logic              tri_q;

	logic [LIMIT_W-1:0] a_nz, v_nz;
	logic signed [32:0] diff;
	logic [31:0]        dist_abs;
	logic [63:0]        mul_sum;
	logic [34:0]        sq_sh, sq_trial;
	logic               sq_ge;
	logic [31:0]        root_nxt;
	logic [31:0]        dv_sh;
	logic               dv_ge;
	logic [63:0]        quo_nxt;
	logic               last;
	logic [31:0]        cruise;

	always_comb begin
		a_nz     = (cfg.accel == '0) ? LIMIT_W'(1) : cfg.accel;
		v_nz     = (cfg.speed == '0) ? LIMIT_W'(1) : cfg.speed;
		diff     = 33'(cfg.end_pos) - 33'(cfg.start_pos);
		dist_abs = diff[32] ? 32'(-diff) : diff[31:0];
		mul_sum  = op_b_q[0] ? res_q + op_a_q : res_q;
		sq_sh    = {rem_q[32:0], op_a_q[63:62]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_sh >= sq_trial;
		root_nxt = {root_q[30:0], sq_ge};
		dv_sh    = {rem_q[30:0], op_a_q[63]};
		dv_ge    = dv_sh >= {1'b0, dv_q};
		quo_nxt  = {res_q[62:0], dv_ge};
		last     = (state_q == S_DIV_TA || state_q == S_DIV_VVA || state_q == S_DIV_CR) ?
			(cnt_q == 6'd63) : (cnt_q == 6'd31);
		cruise   = dist_abs - quo_nxt[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ramp_q  <= '0;
			dur_q   <= '0;
			peak_q  <= '0;
			tri_q   <= 1'b1;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= S_MUL_DA;
			op_a_q  <= {32'b0, dist_abs};
			op_b_q  <= 64'(a_nz);
			res_q   <= '0;
			cnt_q   <= '0;
		end else begin
			cnt_q <= last ? '0 : cnt_q + 6'd1;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
				end
				S_MUL_DA, S_MUL_VV: begin
					res_q  <= mul_sum;
					op_a_q <= op_a_q << 1;
					op_b_q <= op_b_q >> 1;
					if (last && state_q == S_MUL_DA) begin
						prod_da_q <= mul_sum;
						op_a_q    <= 64'(v_nz);
						op_b_q    <= 64'(v_nz);
						res_q     <= '0;
						state_q   <= S_MUL_VV;
					end else if (last) begin
						prod_vv_q <= mul_sum;
						rem_q     <= '0;
						res_q     <= '0;
						if (prod_da_q < mul_sum) begin
							tri_q   <= 1'b1;
							op_a_q  <= prod_da_q;
							root_q  <= '0;
							state_q <= S_SQRT;
						end else begin
							tri_q   <= 1'b0;
							peak_q  <= 32'(v_nz);
							op_a_q  <= {17'b0, v_nz, 16'b0};
							dv_q    <= a_nz;
							state_q <= S_DIV_TA;
						end
					end
				end
				S_SQRT: begin
					root_q <= root_nxt;
					rem_q  <= sq_ge ? sq_sh - sq_trial : sq_sh;
					op_a_q <= op_a_q << 2;
					if (last) begin
						peak_q  <= root_nxt;
						op_a_q  <= {16'b0, root_nxt, 16'b0};
						rem_q   <= '0;
						res_q   <= '0;
						dv_q    <= a_nz;
						state_q <= S_DIV_TA;
					end
				end
				S_DIV_TA, S_DIV_VVA, S_DIV_CR: begin
					res_q  <= quo_nxt;
					rem_q  <= {3'b0, dv_ge ? dv_sh - {1'b0, dv_q} : dv_sh};
					op_a_q <= op_a_q << 1;
					if (last) begin
						rem_q <= '0;
						res_q <= '0;
						if (state_q == S_DIV_TA) begin
							ta_q   <= quo_nxt;
							ramp_q <= sat_time(quo_nxt);
							if (tri_q) begin
								dur_q   <= sat_time(quo_nxt << 1);
								state_q <= S_IDLE;
							end else begin
								op_a_q  <= prod_vv_q;
								dv_q    <= a_nz;
								state_q <= S_DIV_VVA;
							end
						end else if (state_q == S_DIV_VVA) begin
							op_a_q  <= {16'b0, cruise, 16'b0};
							dv_q    <= v_nz;
							state_q <= S_DIV_CR;
						end else begin
							dur_q   <= sat_time((ta_q << 1) + quo_nxt);
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign drv.ramp     = ramp_q;
	assign drv.dur      = dur_q;
	assign drv.peak     = peak_q;
	assign drv.tri_flag = tri_q;
	assign drv.busy     = (state_q != S_IDLE);

endmodule
